// File: rtl/frc_pkg.sv
// Package: shared constants, request codes, FSM states and cell types for the fault recorder.
package frc_pkg;

  localparam int NumCodesDef = 10;
  localparam int NumPoll     = 6;
  localparam int CodeW       = 4;
  localparam int CountW      = 16;
  localparam int TimeW       = 32;
  localparam int IntervalW   = 20;
  localparam int TotalW      = 5;

  localparam logic [CountW-1:0]    CountMax   = 16'hFFFF;
  localparam logic [IntervalW-1:0] FlushReset = 20'd10000;

  typedef enum logic [2:0] {
    REQ_POLL  = 3'd0,
    REQ_TRIP  = 3'd1,
    REQ_CLEAR = 3'd2,
    REQ_FLUSH = 3'd3,
    REQ_READ  = 3'd4
  } frc_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RESP,
    ST_FLUSH
  } frc_state_t;

  typedef struct packed {
    logic              active;
    logic [CountW-1:0] count;
    logic [TimeW-1:0]  tstamp;
  } frc_entry_t;

  typedef struct packed {
    logic level_en;
    logic level_on;
    logic trip;
    logic clear;
    logic load;
    logic shift;
  } frc_cell_ctl_t;

endpackage

// File: rtl/frc_req_if.sv
// Interface: request channel into the fault recorder.
interface frc_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [31:0] now_ms;
  logic [3:0]  code;
  logic        diag_mode;
  logic        speed_trusted;
  logic        speed_hw_started;
  logic        throttle_valid;
  logic        manifold_valid;
  logic        limp_active;
  logic        reverse_abuse;

  modport source (
    output valid, req_type, now_ms, code, diag_mode, speed_trusted, speed_hw_started,
           throttle_valid, manifold_valid, limp_active, reverse_abuse,
    input  ready
  );
  modport sink (
    input  valid, req_type, now_ms, code, diag_mode, speed_trusted, speed_hw_started,
           throttle_valid, manifold_valid, limp_active, reverse_abuse,
    output ready
  );
endinterface

// File: rtl/frc_rsp_if.sv
// Interface: result channel out of the fault recorder.
interface frc_rsp_if;
  logic        valid;
  logic        ready;
  logic [4:0]  active_total;
  logic [3:0]  code_out;
  logic        entry_active;
  logic [15:0] entry_count;
  logic [31:0] entry_time;
  logic        is_flush;
  logic        dirty_flag;
  logic        last;

  modport source (
    output valid, active_total, code_out, entry_active, entry_count, entry_time,
           is_flush, dirty_flag, last,
    input  ready
  );
  modport sink (
    input  valid, active_total, code_out, entry_active, entry_count, entry_time,
           is_flush, dirty_flag, last,
    output ready
  );
endinterface

// File: rtl/frc_cfg_if.sv
// Interface: configuration write channel for the flush interval register.
interface frc_cfg_if;
  logic        valid;
  logic        ready;
  logic [19:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: rtl/frc_cell.sv
// Table cell: one fault code entry plus its stage of the flush shift chain.
module frc_cell
  import frc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  frc_cell_ctl_t    ctl,
  input  logic [TimeW-1:0] now_ms,
  input  frc_entry_t       shift_in,
  output frc_entry_t       entry,
  output frc_entry_t       shift_out,
  output logic             hit
);

  // new occurrence: one-shot trip or rising edge of a polled level
  assign hit = ctl.trip | (ctl.level_en & ctl.level_on & ~entry.active);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
    end else if (ctl.clear) begin
      entry <= '0;
    end else begin
      if (hit) begin
        if (entry.count != CountMax) begin
          entry.count <= entry.count + 1'b1;
        end
        entry.tstamp <= now_ms;
      end
      if (ctl.level_en) begin
        entry.active <= ctl.level_on;
      end
    end
  end

  // snapshot for a flush run, then move one place toward cell 0 per taken flush result
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      shift_out <= entry;
    end else if (ctl.shift) begin
      shift_out <= shift_in;
    end
  end

endmodule

// File: rtl/fault_code_event_recorder_core.sv
// Top level: fault code event recorder built from a row of table cells.
// Each known request other than a flush run has a single result, offered in
// the next cycle after the request is taken. In a flush run the table is
// copied into the shift stages of the cell row when the request is taken,
// and cell 0 then presents one entry per cycle as the row shifts toward it,
// holding while its result is not taken. Requests are taken only while no
// result is pending. Unknown request types are taken and produce no result.
// The flush interval register may be written at any time the block is idle;
// it resets to 10000 ms.
module fault_code_event_recorder_core
  import frc_pkg::*;
#(
  parameter int NUM_CODES = NumCodesDef
) (
  input logic      clk,
  input logic      rst,
  frc_req_if.sink   req,
  frc_rsp_if.source rsp,
  frc_cfg_if.sink   cfg
);

  frc_state_t state, state_next;

  logic [IntervalW-1:0] flush_interval;
  logic                 dirty;
  logic [TimeW-1:0]     last_flush;
  logic                 has_entry;
  logic [CodeW-1:0]     code_r;
  logic [CodeW-1:0]     flush_cnt;

  logic req_acc, rsp_acc, shift_en;
  logic is_poll, is_trip, is_clear, is_flush_req, is_read, is_known;
  logic flush_due, code_ok, any_hit, flush_last;
  logic [NumPoll-1:0]   poll_raise;
  logic [NUM_CODES-1:0] level_raise;
  logic [TimeW-1:0]     elapsed;

  frc_cell_ctl_t ctl     [NUM_CODES];
  frc_entry_t    entry   [NUM_CODES];
  frc_entry_t    shadow  [NUM_CODES];
  logic          hit_vec [NUM_CODES];

  frc_entry_t       sel_entry;
  logic [TotalW-1:0] total;

  assign cfg.ready = 1'b1;

  assign req_acc = req.valid & req.ready;
  assign rsp_acc = rsp.valid & rsp.ready;

  assign is_poll      = req.req_type == REQ_POLL;
  assign is_trip      = req.req_type == REQ_TRIP;
  assign is_clear     = req.req_type == REQ_CLEAR;
  assign is_flush_req = req.req_type == REQ_FLUSH;
  assign is_read      = req.req_type == REQ_READ;
  assign is_known     = is_poll | is_trip | is_clear | is_flush_req | is_read;

  assign code_ok   = {1'b0, req.code} < (CodeW+1)'(NUM_CODES);
  assign elapsed   = req.now_ms - last_flush;
  assign flush_due = is_flush_req & dirty &
                     (elapsed >= {{(TimeW-IntervalW){1'b0}}, flush_interval});

  assign poll_raise[0] = ~req.diag_mode & ~req.speed_trusted;
  assign poll_raise[1] = ~req.diag_mode & ~req.speed_hw_started;
  assign poll_raise[2] = ~req.diag_mode & ~req.throttle_valid;
  assign poll_raise[3] = ~req.diag_mode & ~req.manifold_valid;
  assign poll_raise[4] = req.limp_active;
  assign poll_raise[5] = req.reverse_abuse;

  assign level_raise = NUM_CODES'(poll_raise);

  assign flush_last = flush_cnt == CodeW'(NUM_CODES - 1);

  // cell row
  for (genvar i = 0; i < NUM_CODES; i++) begin : g_cell
    always_comb begin
      ctl[i].level_en = 1'b0;
      ctl[i].level_on = 1'b0;
      if (i < NumPoll) begin
        ctl[i].level_en = req_acc & is_poll;
        ctl[i].level_on = level_raise[i];
      end
      ctl[i].trip  = req_acc & is_trip & (req.code == CodeW'(i));
      ctl[i].clear = req_acc & is_clear;
      ctl[i].load  = req_acc & flush_due;
      ctl[i].shift = shift_en;
    end

    frc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl[i]),
      .now_ms    (req.now_ms),
      .shift_in  ((i == NUM_CODES - 1) ? frc_entry_t'('0) : shadow[(i + 1) % NUM_CODES]),
      .entry     (entry[i]),
      .shift_out (shadow[i]),
      .hit       (hit_vec[i])
    );
  end

  always_comb begin
    any_hit   = 1'b0;
    total     = '0;
    sel_entry = '0;
    for (int i = 0; i < NUM_CODES; i++) begin
      any_hit = any_hit | hit_vec[i];
      total   = total + TotalW'(entry[i].active);
      if (code_r == CodeW'(i)) begin
        sel_entry = entry[i];
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      flush_interval <= FlushReset;
      dirty          <= 1'b0;
      last_flush     <= '0;
      has_entry      <= 1'b0;
      code_r         <= '0;
      flush_cnt      <= '0;
    end else begin
      state <= state_next;
      if (cfg.valid & cfg.ready) begin
        flush_interval <= cfg.data;
      end
      if (req_acc) begin
        has_entry <= (is_trip | is_read) & code_ok;
        code_r    <= req.code;
        if (flush_due) begin
          dirty      <= 1'b0;
          last_flush <= req.now_ms;
        end else if (is_clear | any_hit) begin
          dirty <= 1'b1;
        end
      end
      if (req_acc & flush_due) begin
        flush_cnt <= '0;
      end else if (shift_en) begin
        flush_cnt <= flush_cnt + 1'b1;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_acc && is_known) begin
          state_next = flush_due ? ST_FLUSH : ST_RESP;
        end
      end
      ST_RESP: begin
        if (rsp_acc) begin
          state_next = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (rsp_acc && flush_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req.ready        = 1'b0;
    rsp.valid        = 1'b0;
    shift_en         = 1'b0;
    rsp.code_out     = '0;
    rsp.entry_active = 1'b0;
    rsp.entry_count  = '0;
    rsp.entry_time   = '0;
    rsp.is_flush     = 1'b0;
    rsp.last         = 1'b1;
    unique case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
      end
      ST_RESP: begin
        rsp.valid = 1'b1;
        if (has_entry) begin
          rsp.code_out     = code_r;
          rsp.entry_active = sel_entry.active;
          rsp.entry_count  = sel_entry.count;
          rsp.entry_time   = sel_entry.tstamp;
        end
      end
      ST_FLUSH: begin
        rsp.valid        = 1'b1;
        shift_en         = rsp_acc;
        rsp.code_out     = flush_cnt;
        rsp.entry_active = shadow[0].active;
        rsp.entry_count  = shadow[0].count;
        rsp.entry_time   = shadow[0].tstamp;
        rsp.is_flush     = 1'b1;
        rsp.last         = flush_last;
      end
      default: begin
        req.ready = 1'b0;
      end
    endcase
  end

  assign rsp.active_total = total;
  assign rsp.dirty_flag   = dirty;

endmodule
